>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hdl/lpgc_pkg.sv
`timescale 1ns / 1ps

package lpgc_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int LANES_DEF       = 16;

	localparam int POS_W = 10;
	localparam int KEY_W = 32;
	localparam int CNT_W = 32;
	localparam int CFG_W = 11;

	// APB register map
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_TABLE_SIZE = 1'b0;
	localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 11'd1024;

	localparam logic ACT_COUNT = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] position;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0] slot;
		logic [KEY_W-1:0] key_out;
		logic [CNT_W-1:0] count;
		logic             table_full;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ISSUE,
		ST_CMP
	} state_t;

endpackage

>>> hdl/linear_probing_group_count_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// cmd       start / busy            cmd_t  {action, key, position}
// result    done (one-cycle strobe) res_t  {slot, key_out, count, table_full}
// config    APB psel/penable/pwrite paddr, pwdata, prdata (table_size at 0x0)
//
// A read, or a count that settles in its first block, is accepted with the row read,
// then compared, and a count that lands is written back; the result shows the cycle after.
// Each further block probed adds one row read and compare.
// A count whose bucket is at or above the table size first runs the bit-serial remainder.
// Reset empties the table at once through per-row valid bits; no clearing pass.
// busy stays high until the compare finishes and any row write is done; results cannot be stalled.

module linear_probing_group_count_unit
	import lpgc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int LANES       = LANES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              done,
	output res_t              result
);

	// TABLE_DEPTH and LANES are powers of two
	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int LB   = $clog2(LANES);
	localparam int RW   = IW - LB;
	localparam int RW1  = RW + 1;
	localparam int ROWS = TABLE_DEPTH / LANES;
	localparam int SZW  = IW + 1;
	localparam int SZW1 = SZW + 1;
	localparam int PW   = (IW > POS_W) ? IW : POS_W;
	localparam int DCW  = $clog2(POS_W);

	typedef logic [LANES-1:0][KEY_W-1:0] row_t;

	// config
	logic [CFG_W-1:0] table_size_q;
	logic             cfg_wr;
	logic [SZW-1:0]   size_w;
	logic [SZW:0]     nsum_w;
	logic [RW:0]      nrows_w;

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   rd_en;
	logic   wr_en;
	logic   fin;
	logic [RW-1:0] rd_addr;

	// memories
	row_t key_mem [ROWS];
	row_t cnt_mem [ROWS];
	row_t key_rd_s1, cnt_rd_s1;
	logic rdv_s1;
	logic [ROWS-1:0] vld_q;
	row_t key_row, cnt_row, key_wr, cnt_wr;

	// item context
	logic             act_q;
	logic [KEY_W-1:0] key_q;
	logic [POS_W-1:0] bucket_q;
	logic             oob_q;
	logic [RW-1:0]    row_q;
	logic [RW:0]      step_q;
	logic             first_q;

	// remainder unit
	logic [SZW:0]     rem_q, rem_t, rem_d;
	logic [POS_W-1:0] dsh_q;
	logic [DCW-1:0]   dcnt_q;

	// lane compare
	logic [LANES-1:0] hit_v, emp_v;
	logic             hit_f, emp_f;
	logic [LB-1:0]    hit_l, emp_l, sel_l, bkt_l;
	logic [RW-1:0]    row_nx;
	logic [CNT_W-1:0] cnt_new;
	logic [PW-1:0]    pos_ext, bkt_ext, slot_ext;
	logic [RW-1:0]    pos_row, bkt_row;
	logic             pos_lt_size;

	res_t res_d, res_q;
	logic done_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
		end else if (cfg_wr) begin
			table_size_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_TABLE_SIZE) begin
			prdata = 32'(table_size_q);
		end
	end

	// size in use, clamped to 1..TABLE_DEPTH, and the block count
	always_comb begin
		if (table_size_q == '0) begin
			size_w = SZW'(1);
		end else if (32'(table_size_q) > TABLE_DEPTH) begin
			size_w = SZW'(TABLE_DEPTH);
		end else begin
			size_w = SZW'(table_size_q);
		end
		nsum_w  = {1'b0, size_w} + SZW1'(LANES - 1);
		nrows_w = RW1'(nsum_w >> LB);
	end

	// ---------------- address helpers ----------------
	assign accept      = start && !busy;
	assign pos_ext     = PW'(cmd.position);
	assign pos_row     = pos_ext[IW-1:LB];
	assign pos_lt_size = 32'(cmd.position) < 32'(size_w);
	assign bkt_ext     = PW'(bucket_q);
	assign bkt_row     = bkt_ext[IW-1:LB];
	assign bkt_l       = bucket_q[LB-1:0];

	assign row_nx = ((RW1'(row_q) + RW1'(1)) >= nrows_w) ? '0 : row_q + RW'(1);

	// remainder step: one quotient bit per cycle
	assign rem_t = {rem_q[SZW-1:0], dsh_q[POS_W-1]};
	assign rem_d = (rem_t >= {1'b0, size_w}) ? rem_t - {1'b0, size_w} : rem_t;

	// ---------------- row compare ----------------
	assign key_row = rdv_s1 ? key_rd_s1 : '0;
	assign cnt_row = rdv_s1 ? cnt_rd_s1 : '0;

	always_comb begin
		logic slot_ok;
		for (int l = 0; l < LANES; l++) begin
			slot_ok  = 32'({row_q, LB'(l)}) < 32'(size_w);
			hit_v[l] = slot_ok && (key_row[l] == key_q);
			emp_v[l] = slot_ok && (key_row[l] == '0) && (!first_q || (LB'(l) >= bkt_l));
		end
	end

	// lowest matching lane wins
	always_comb begin
		hit_l = '0;
		emp_l = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (hit_v[l]) begin
				hit_l = LB'(l);
			end
			if (emp_v[l]) begin
				emp_l = LB'(l);
			end
		end
		hit_f = |hit_v;
		emp_f = |emp_v;
		sel_l = hit_f ? hit_l : emp_l;
	end

	assign cnt_new  = cnt_row[sel_l] + CNT_W'(1);
	assign slot_ext = PW'({row_q, sel_l});

	always_comb begin
		key_wr        = key_row;
		cnt_wr        = cnt_row;
		key_wr[sel_l] = key_q;
		cnt_wr[sel_l] = cnt_new;
	end

	// ---------------- state machine ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = row_q;
		wr_en   = 1'b0;
		fin     = 1'b0;
		res_d   = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = pos_row;
				if (accept) begin
					rd_en = 1'b1;
					if (cmd.action == ACT_COUNT && !pos_lt_size) begin
						state_d = ST_DIV;
					end else begin
						state_d = ST_CMP;
					end
				end
			end
			ST_DIV: begin
				if (dcnt_q == DCW'(POS_W - 1)) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				rd_en   = 1'b1;
				rd_addr = bkt_row;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				res_d.slot = bucket_q;
				if (act_q == ACT_READ) begin
					fin = 1'b1;
					if (!oob_q) begin
						res_d.key_out = key_row[bkt_l];
						res_d.count   = cnt_row[bkt_l];
					end
				end else if (key_q == '0) begin
					fin           = 1'b1;
					res_d.key_out = key_row[bkt_l];
					res_d.count   = cnt_row[bkt_l];
				end else if (hit_f || emp_f) begin
					fin           = 1'b1;
					wr_en         = 1'b1;
					res_d.slot    = slot_ext[POS_W-1:0];
					res_d.key_out = key_q;
					res_d.count   = cnt_new;
				end else if (step_q == nrows_w) begin
					// every block and the first again: table full
					fin              = 1'b1;
					res_d.table_full = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = row_nx;
				end
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- item context and remainder unit ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					act_q    <= cmd.action;
					key_q    <= cmd.key;
					bucket_q <= cmd.position;
					oob_q    <= 32'(pos_ext) >= TABLE_DEPTH;
					row_q    <= pos_row;
					step_q   <= '0;
					first_q  <= 1'b1;
					rem_q    <= '0;
					dsh_q    <= cmd.position;
					dcnt_q   <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= rem_d;
				dsh_q  <= {dsh_q[POS_W-2:0], 1'b0};
				dcnt_q <= dcnt_q + DCW'(1);
				if (dcnt_q == DCW'(POS_W - 1)) begin
					bucket_q <= POS_W'(rem_d);
				end
			end
			ST_ISSUE: begin
				row_q <= bkt_row;
			end
			ST_CMP: begin
				if (rd_en) begin
					row_q   <= row_nx;
					step_q  <= step_q + RW1'(1);
					first_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------- table memories ----------------
	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_s1 <= key_mem[rd_addr];
			cnt_rd_s1 <= cnt_mem[rd_addr];
		end
		if (wr_en) begin
			key_mem[row_q] <= key_wr;
			cnt_mem[row_q] <= cnt_wr;
		end
	end

	// a row never written reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				rdv_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[row_q] <= 1'b1;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// ---------------- checks ----------------
`include "assert_macros.svh"

	`ASSERT_CLK(a_done_after_cmp, done |-> $past(state_q == ST_CMP), "result without compare")
	`ASSERT_NEVER(a_wr_outside_cmp, wr_en && (state_q != ST_CMP), "row write outside compare")
	`ASSERT_NEVER(a_rd_wr_same_row, rd_en && wr_en && (rd_addr == row_q), "read and write collide")
	`ASSERT_CLK(a_accept_busy, accept |=> busy, "accepted beat did not raise busy")
	`ASSERT_CLK(a_full_empty_res, done && result.table_full |-> (result.key_out == '0) && (result.count == '0), "full result carries data")

endmodule

>>> tb/tb_linear_probing_group_count_unit.sv
`timescale 1ns / 1ps

module tb_linear_probing_group_count_unit;
	import lpgc_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int LN    = LANES_DEF;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              start;
	logic              busy;
	cmd_t              cmd;
	logic              done;
	res_t              result;

	// shadow of the hash table and of the size register
	logic [KEY_W-1:0] key_tbl [DEPTH];
	logic [CNT_W-1:0] cnt_tbl [DEPTH];
	logic [CFG_W-1:0] tbl_size;

	res_t due_results [$];
	int   err_cnt;
	int   idle_pct;

	linear_probing_group_count_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_linear_probing_group_count_unit: done, errors");
		$finish;
	end

	function automatic int unsigned slots_in_use();
		if (tbl_size == '0)
			return 1;
		if (tbl_size > DEPTH)
			return DEPTH;
		return tbl_size;
	endfunction

	// Apply one command to the shadow table and return the result it reports.
	function automatic res_t count_in_table(cmd_t c);
		res_t        r;
		int unsigned size, bucket, base, nblk, from, s, stp, ln;
		int          hit, hole;
		r = '0;
		if (c.action == ACT_READ) begin
			r.slot    = c.position;
			r.key_out = key_tbl[c.position];
			r.count   = cnt_tbl[c.position];
			return r;
		end
		size   = slots_in_use();
		bucket = c.position % size;
		r.slot = POS_W'(bucket);
		if (c.key == '0) begin
			r.key_out = key_tbl[bucket];
			r.count   = cnt_tbl[bucket];
			return r;
		end
		base = bucket - (bucket % LN);
		nblk = (size + LN - 1) / LN;
		from = bucket % LN;
		for (stp = 0; stp <= nblk; stp++) begin
			hit  = -1;
			hole = -1;
			for (ln = 0; ln < LN; ln++) begin
				s = base + ln;
				if (s >= size)
					break;
				if (hit < 0 && key_tbl[s] == c.key)
					hit = ln;
				if (hole < 0 && ln >= from && key_tbl[s] == '0)
					hole = ln;
			end
			if (hit >= 0 || hole >= 0) begin
				s = base + ((hit >= 0) ? hit : hole);
				key_tbl[s] = c.key;
				cnt_tbl[s] = cnt_tbl[s] + 1'b1;
				r.slot     = POS_W'(s);
				r.key_out  = key_tbl[s];
				r.count    = cnt_tbl[s];
				return r;
			end
			// advance to the next block, wrap at the table size
			from = 0;
			base += LN;
			if (base >= size)
				base = 0;
		end
		r.table_full = 1'b1;
		return r;
	endfunction

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				$error("result beat with nothing pending: slot %0d", result.slot);
				err_cnt++;
			end else begin
				want = due_results.pop_front();
				if (result.slot !== want.slot) begin
					$error("slot: expected %0d, actual %0d", want.slot, result.slot);
					err_cnt++;
				end
				if (result.key_out !== want.key_out) begin
					$error("key_out: expected %h, actual %h", want.key_out, result.key_out);
					err_cnt++;
				end
				if (result.count !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, result.count);
					err_cnt++;
				end
				if (result.table_full !== want.table_full) begin
					$error("table_full: expected %b, actual %b", want.table_full,
						result.table_full);
					err_cnt++;
				end
			end
		end
	end

	task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
			input logic [POS_W-1:0] p);
		cmd_t c;
		int   gap;
		c.action   = act;
		c.key      = k;
		c.position = p;
		@(negedge clk);
		if ($urandom_range(99) < idle_pct) begin
			// drop start and put noise on the bus for a while
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			cmd   <= '{action: 1'($urandom), key: $urandom, position: POS_W'($urandom)};
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		due_results.push_back(count_in_table(c));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0 || busy);
	endtask

	task automatic apb_beat(input logic wr, input logic [31:0] wdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_TABLE_SIZE, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			tbl_size = wdata[CFG_W-1:0];
		else if (prdata !== {{(32 - CFG_W){1'b0}}, tbl_size}) begin
			$error("table_size readback: expected %0d, actual %0d", tbl_size, prdata);
			err_cnt++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_table_size(input int unsigned val);
		wait_drained();
		repeat (3) @(posedge clk);
		apb_beat(1'b1, val);
		apb_beat(1'b0, '0);
	endtask

	task automatic test_basic_counts();
		send_item(ACT_COUNT, 32'hFFFF_FFFF, 10'd1023);
		send_item(ACT_COUNT, 32'hFFFF_FFFF, 10'd1023);
		send_item(ACT_COUNT, 32'd1, 10'd0);
		send_item(ACT_COUNT, 32'd2, 10'd15);
		// bucket taken at the last lane: spill into the next block
		send_item(ACT_COUNT, 32'd3, 10'd15);
		send_item(ACT_COUNT, 32'd4, 10'd3);
		// key sits below the bucket in the same block
		send_item(ACT_COUNT, 32'd4, 10'd8);
		// last block full from the bucket on: wrap to block zero
		send_item(ACT_COUNT, 32'd5, 10'd1023);
		send_item(ACT_COUNT, 32'd0, 10'd5);
		send_item(ACT_READ, 32'hA5A5_5A5A, 10'd1023);
		send_item(ACT_READ, 32'd0, 10'd0);
		send_item(ACT_READ, 32'd0, 10'd600);
	endtask

	task automatic test_size_extremes();
		set_table_size(16);
		send_item(ACT_COUNT, 32'd1, 10'd1000);
		send_item(ACT_COUNT, 32'h8000_0000, 10'd1023);
		send_item(ACT_READ, 32'd0, 10'd900);
		// size zero saturates to one slot, already holding a key
		set_table_size(0);
		send_item(ACT_COUNT, 32'd7, 10'd777);
		send_item(ACT_COUNT, 32'd1, 10'd3);
		set_table_size(2047);
		send_item(ACT_COUNT, 32'd9, 10'd1023);
		send_item(ACT_COUNT, 32'hFFFF_FFFF, 10'd1008);
	endtask

	task automatic test_random_mix(input int unsigned size_val, input int n, input int idle);
		logic [KEY_W-1:0] pool [$];
		int unsigned      span, npool;
		int               i, r;
		logic [POS_W-1:0] p;
		set_table_size(size_val);
		idle_pct = idle;
		span  = slots_in_use();
		npool = (span + 8 < 64) ? span + 8 : 64;
		pool.delete();
		for (i = 0; i < npool; i++)
			pool.push_back($urandom);
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			p = ($urandom_range(99) < 70) ? POS_W'($urandom_range(span - 1))
				: POS_W'($urandom_range(DEPTH - 1));
			if (r < 10)
				send_item(ACT_READ, $urandom, p);
			else if (r < 14)
				send_item(ACT_COUNT, '0, p);
			else if (r < 24)
				send_item(ACT_COUNT, $urandom, p);
			else
				send_item(ACT_COUNT, pool[$urandom_range(npool - 1)], p);
			if ($urandom_range(99) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		start    = 1'b0;
		cmd      = '0;
		err_cnt  = 0;
		idle_pct = 0;
		tbl_size = TABLE_SIZE_RST;
		for (int i = 0; i < DEPTH; i++) begin
			key_tbl[i] = '0;
			cnt_tbl[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_counts();
		test_size_extremes();

		test_random_mix(16, 150, 12);
		test_random_mix(1024, 200, 12);
		test_random_mix(48, 50, 12);
		test_random_mix(17, 150, 69);
		test_random_mix(0, 30, 69);
		test_random_mix(2047, 150, 69);
		test_random_mix(33, 150, 0);
		test_random_mix($urandom_range(16, 1024), 200, 0);
		test_random_mix(1024, 100, 0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && due_results.size() == 0)
			$display("tb_linear_probing_group_count_unit: done, clean");
		else
			$display("tb_linear_probing_group_count_unit: done, errors");
		$finish;
	end

endmodule
